FILE: hw/rtl/rgbyc_pkg.sv
// ----------------------------------------------------------------------------
// rgbyc_pkg: shared types and constants for the RGB to YCbCr blend core
// Fixed-point formats, conversion coefficients and the item structs.
// ----------------------------------------------------------------------------
package rgbyc_pkg;

	localparam int FRAC_BITS = 12;
	localparam int CONV_FRAC = 16;
	localparam int NUM_CH    = 3;
	localparam int BYTE_W    = 8;
	localparam int RGB_W     = FRAC_BITS + 4;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int THR_W     = FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FRAC_W;
	localparam logic [CFG_IDX_W-1:0] REG_FADE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_EN   = 2'd2;

	localparam logic [FRAC_W-1:0] ONE            = FRAC_W'(1 << FRAC_BITS);
	localparam logic [FRAC_W-1:0] FADE_RESET     = ONE;
	localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(4);

	// datapath widths
	localparam int WEIGHT_W    = 2 * FRAC_BITS + 1;
	localparam int COEF_W      = 25;
	localparam int PROD_W      = COEF_W + RGB_W;
	localparam int ACC_W       = PROD_W + 2;
	localparam int T_W         = ACC_W - FRAC_BITS;
	localparam int D_W         = T_W + 1;
	localparam int MUL_W       = D_W + WEIGHT_W + 1;
	localparam int TOTAL_SHIFT = CONV_FRAC + 2 * FRAC_BITS;
	localparam int R_W         = MUL_W - TOTAL_SHIFT;
	localparam int BIAS_W      = BYTE_W + 2;

	localparam logic [BYTE_W-1:0] CHROMA_OFS = BYTE_W'(128);
	localparam logic [BYTE_W-1:0] BYTE_MAX   = BYTE_W'(255);

	// 255*K in Q.16, rows Y, Cb, Cr; columns R, G, B
	localparam logic signed [COEF_W-1:0] COEF [NUM_CH][NUM_CH] = '{
		'{ 25'sd4996792,  25'sd9809756,  25'sd1905132},
		'{-25'sd2819860, -25'sd5535980,  25'sd8355840},
		'{ 25'sd8355840, -25'sd6996973, -25'sd1358867}
	};

	typedef logic [BYTE_W-1:0] byte_t;
	typedef byte_t [NUM_CH-1:0] trio_t;
	typedef logic signed [D_W-1:0] diff_t;
	typedef logic signed [MUL_W-1:0] mul_t;

	typedef struct packed {
		logic signed [RGB_W-1:0] red;
		logic signed [RGB_W-1:0] green;
		logic signed [RGB_W-1:0] blue;
		logic [FRAC_W-1:0]       mask;
		byte_t                   old_luma;
		byte_t                   old_cb;
		byte_t                   old_cr;
		logic                    row_end;
	} pixel_in_t;

	typedef struct packed {
		byte_t new_luma;
		byte_t new_cb;
		byte_t new_cr;
		logic  row_end_out;
	} pixel_out_t;

	// blend weight and bypass decision for one item
	typedef struct packed {
		logic                keep;
		logic [WEIGHT_W-1:0] s;
	} weight_t;

	// fields that ride along the pipeline unchanged
	typedef struct packed {
		trio_t old;
		logic  row_end;
	} side_t;

endpackage

FILE: hw/rtl/rgbyc_weight.sv
// ----------------------------------------------------------------------------
// rgbyc_weight: blend weight and bypass decision
// Forms mask*fade or fade<<FRAC_BITS, registered and delayed to stage two.
// ----------------------------------------------------------------------------
module rgbyc_weight (
	input  logic                                clk,
	input  logic [rgbyc_pkg::FRAC_W-1:0]        fade,
	input  logic [rgbyc_pkg::THR_W-1:0]         select_threshold,
	input  logic                                mask_enable,
	input  logic [rgbyc_pkg::FRAC_W-1:0]        mask,
	output rgbyc_pkg::weight_t                  weight_s2
);

	logic [rgbyc_pkg::FRAC_W-1:0] fade_sat;
	logic [rgbyc_pkg::FRAC_W-1:0] fade_eff;
	logic [rgbyc_pkg::FRAC_W-1:0] mask_sat;
	logic [rgbyc_pkg::FRAC_W-1:0] thr_ext;
	logic [2*rgbyc_pkg::FRAC_W-1:0] mask_prod;
	rgbyc_pkg::weight_t weight_d;
	rgbyc_pkg::weight_t weight_s1;

	always_comb begin
		thr_ext  = rgbyc_pkg::FRAC_W'(select_threshold);
		fade_sat = (fade > rgbyc_pkg::ONE) ? rgbyc_pkg::ONE : fade;
		mask_sat = (mask > rgbyc_pkg::ONE) ? rgbyc_pkg::ONE : mask;
		// near one counts as exactly one
		fade_eff = (fade_sat >= rgbyc_pkg::ONE - thr_ext) ? rgbyc_pkg::ONE : fade_sat;
		mask_prod = (2*rgbyc_pkg::FRAC_W)'(mask_sat) * (2*rgbyc_pkg::FRAC_W)'(fade_eff);
		weight_d.keep = (fade_sat <= thr_ext);
		if (mask_enable) begin
			weight_d.s = mask_prod[rgbyc_pkg::WEIGHT_W-1:0];
		end else begin
			weight_d.s = {fade_eff, {(rgbyc_pkg::WEIGHT_W-rgbyc_pkg::FRAC_W){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= weight_d;
		weight_s2 <= weight_s1;
	end

endmodule

FILE: hw/rtl/rgbyc_convert.sv
// ----------------------------------------------------------------------------
// rgbyc_convert: RGB to YCbCr target, minus the old pixel
// Stage one forms the nine coefficient products, stage two sums and offsets.
// ----------------------------------------------------------------------------
module rgbyc_convert (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  rgbyc_pkg::pixel_in_t    pixel,
	output logic                    valid_s2,
	output rgbyc_pkg::diff_t        diff_s2 [rgbyc_pkg::NUM_CH],
	output rgbyc_pkg::side_t        side_s2
);

	logic signed [rgbyc_pkg::RGB_W-1:0]  rgb [rgbyc_pkg::NUM_CH];
	logic signed [rgbyc_pkg::PROD_W-1:0] prod_s1 [rgbyc_pkg::NUM_CH][rgbyc_pkg::NUM_CH];
	logic                                valid_s1;
	rgbyc_pkg::side_t                    side_in;
	rgbyc_pkg::side_t                    side_s1;
	logic signed [rgbyc_pkg::ACC_W-1:0]  acc [rgbyc_pkg::NUM_CH];
	logic signed [rgbyc_pkg::T_W-1:0]    tgt [rgbyc_pkg::NUM_CH];
	logic signed [rgbyc_pkg::BIAS_W-1:0] bias [rgbyc_pkg::NUM_CH];
	rgbyc_pkg::diff_t                    diff_d [rgbyc_pkg::NUM_CH];
	rgbyc_pkg::byte_t                    ofs;

	always_comb begin
		rgb[0] = pixel.red;
		rgb[1] = pixel.green;
		rgb[2] = pixel.blue;
		side_in.old[0]  = pixel.old_luma;
		side_in.old[1]  = pixel.old_cb;
		side_in.old[2]  = pixel.old_cr;
		side_in.row_end = pixel.row_end;
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < rgbyc_pkg::NUM_CH; c++) begin
			for (int k = 0; k < rgbyc_pkg::NUM_CH; k++) begin
				prod_s1[c][k] <= rgbyc_pkg::PROD_W'(rgbyc_pkg::COEF[c][k])
					* rgbyc_pkg::PROD_W'(rgb[k]);
			end
		end
		side_s1 <= side_in;
	end

	// floor to Q.16, add the chroma offset, subtract old<<16
	always_comb begin
		ofs = '0;
		for (int c = 0; c < rgbyc_pkg::NUM_CH; c++) begin
			acc[c] = rgbyc_pkg::ACC_W'(prod_s1[c][0]) + rgbyc_pkg::ACC_W'(prod_s1[c][1])
				+ rgbyc_pkg::ACC_W'(prod_s1[c][2]);
			tgt[c] = acc[c][rgbyc_pkg::ACC_W-1:rgbyc_pkg::FRAC_BITS];
			ofs = (c == 0) ? '0 : rgbyc_pkg::CHROMA_OFS;
			bias[c] = $signed({2'b00, ofs}) - $signed({2'b00, side_s1.old[c]});
			diff_d[c] = rgbyc_pkg::D_W'(tgt[c])
				+ (rgbyc_pkg::D_W'(bias[c]) <<< rgbyc_pkg::CONV_FRAC);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < rgbyc_pkg::NUM_CH; c++) begin
			diff_s2[c] <= diff_d[c];
		end
		side_s2 <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

endmodule

FILE: hw/rtl/rgbyc_blend.sv
// ----------------------------------------------------------------------------
// rgbyc_blend: weighted blend, rounding and saturation
// Stage three multiplies by the weight, stage four rounds, clamps (or keeps the old pixel) and drives.
// ----------------------------------------------------------------------------
module rgbyc_blend (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s2,
	input  rgbyc_pkg::diff_t        diff_s2 [rgbyc_pkg::NUM_CH],
	input  rgbyc_pkg::side_t        side_s2,
	input  rgbyc_pkg::weight_t      weight_s2,
	output logic                    result_valid_q,
	output rgbyc_pkg::pixel_out_t   result_q
);

	rgbyc_pkg::mul_t                   mul_s3 [rgbyc_pkg::NUM_CH];
	rgbyc_pkg::side_t                  side_s3;
	logic                              keep_s3;
	logic                              valid_s3;
	rgbyc_pkg::mul_t                   sum [rgbyc_pkg::NUM_CH];
	logic signed [rgbyc_pkg::R_W-1:0]  rnd [rgbyc_pkg::NUM_CH];
	rgbyc_pkg::trio_t                  px;
	rgbyc_pkg::pixel_out_t             result_d;

	always_ff @(posedge clk) begin
		for (int c = 0; c < rgbyc_pkg::NUM_CH; c++) begin
			mul_s3[c] <= rgbyc_pkg::MUL_W'(diff_s2[c])
				* rgbyc_pkg::MUL_W'($signed({1'b0, weight_s2.s}));
		end
		side_s3 <= side_s2;
		keep_s3 <= weight_s2.keep;
	end

	// add old<<40 and half, floor, clamp to a byte
	always_comb begin
		for (int c = 0; c < rgbyc_pkg::NUM_CH; c++) begin
			sum[c] = mul_s3[c]
				+ (rgbyc_pkg::MUL_W'($signed({1'b0, side_s3.old[c]})) <<< rgbyc_pkg::TOTAL_SHIFT)
				+ (rgbyc_pkg::MUL_W'(1) <<< (rgbyc_pkg::TOTAL_SHIFT - 1));
			rnd[c] = sum[c][rgbyc_pkg::MUL_W-1:rgbyc_pkg::TOTAL_SHIFT];
			if (keep_s3) begin
				px[c] = side_s3.old[c];
			end else if (rnd[c] < 0) begin
				px[c] = '0;
			end else if (rnd[c] > rgbyc_pkg::R_W'(rgbyc_pkg::BYTE_MAX)) begin
				px[c] = rgbyc_pkg::BYTE_MAX;
			end else begin
				px[c] = rnd[c][rgbyc_pkg::BYTE_W-1:0];
			end
		end
		result_d.new_luma    = px[0];
		result_d.new_cb      = px[1];
		result_d.new_cr      = px[2];
		result_d.row_end_out = side_s3.row_end;
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s3       <= valid_s2;
			result_valid_q <= valid_s3;
		end
	end

endmodule

FILE: hw/rtl/rgb_to_ycbcr8_masked_blend_core.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr8_masked_blend_core: BT.601 full-range RGB to YCbCr with blend
// Converts a Q3.12 RGB pixel to 8-bit YCbCr and blends it into the old pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive pixel and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays low, so one
//   pixel can enter on every clock.
//   Result channel: result_valid pulses for one cycle with the blended pixel
//   on result. There is no back-pressure: the receiver must take it then.
//   Throughput is one item per cycle, set by a four-stage pipeline
//   (coefficient products, sum and offset, weight multiply, round and
//   clamp) with no shared unit.
//   Configuration: write fade, select_threshold or mask_enable through the
//   cfg channel (cfg_ready is always high) while no item is in flight.
//   Unknown indexes are dropped.
//   Reset (arst_n low): empties the pipeline, fade returns to one, threshold
//   to 4 and mask_enable to 0. No result is produced for items in flight.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr8_masked_blend_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  rgbyc_pkg::pixel_in_t                  pixel,
	output logic                                  result_valid,
	output rgbyc_pkg::pixel_out_t                 result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rgbyc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rgbyc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [rgbyc_pkg::FRAC_W-1:0] fade_q;
	logic [rgbyc_pkg::THR_W-1:0]  threshold_q;
	logic                         mask_en_q;
	logic                         accept;
	logic                         valid_s2;
	rgbyc_pkg::diff_t             diff_s2 [rgbyc_pkg::NUM_CH];
	rgbyc_pkg::side_t             side_s2;
	rgbyc_pkg::weight_t           weight_s2;

	// pipeline never stalls; the config port never holds off a write
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q      <= rgbyc_pkg::FADE_RESET;
			threshold_q <= rgbyc_pkg::THRESHOLD_RESET;
			mask_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgbyc_pkg::REG_FADE: begin
					fade_q <= cfg_data;
				end
				rgbyc_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[rgbyc_pkg::THR_W-1:0];
				end
				rgbyc_pkg::REG_MASK_EN: begin
					mask_en_q <= cfg_data[0];
				end
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// weight and bypass decision, aligned to stage two
	rgbyc_weight u_weight (
		.clk              (clk),
		.fade             (fade_q),
		.select_threshold (threshold_q),
		.mask_enable      (mask_en_q),
		.mask             (pixel.mask),
		.weight_s2        (weight_s2)
	);

	// color conversion: target minus old pixel, in Q.16
	rgbyc_convert u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (accept),
		.pixel    (pixel),
		.valid_s2 (valid_s2),
		.diff_s2  (diff_s2),
		.side_s2  (side_s2)
	);

	// blend, round, saturate and drive the result register
	rgbyc_blend u_blend (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s2       (valid_s2),
		.diff_s2        (diff_s2),
		.side_s2        (side_s2),
		.weight_s2      (weight_s2),
		.result_valid_q (result_valid),
		.result_q       (result)
	);

	// every accepted item leaves the pipeline as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 result_valid)
		else $error("accepted item did not produce a result after four cycles");

	// no result without a matching accepted item
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, 4))
		else $error("result without a matching accepted item");

	// row-end flag travels with its own item
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.row_end_out == $past(pixel.row_end, 4)))
		else $error("row_end_out does not match the item's row_end");

endmodule
